/* rtl/vmvt_pkg.sv */
// vmvt_pkg: constants, codes and pipeline stage types for the von mises trial block
// no dependencies; used by rtl/von_mises_variate_trial.sv and sim/tb.sv
`timescale 1ns / 1ps

package vmvt_pkg;

  // divider and log-squaring iterations, one per stage
  localparam int unsigned LoopSteps = 30;

  localparam logic [29:0] PiQ28     = 30'd843314857;
  localparam logic [29:0] HalfPiQ28 = 30'd421657428;
  localparam logic [29:0] Ln2Q30    = 30'd744261118;
  localparam logic [31:0] TwoQ30    = 32'h8000_0000;
  localparam logic [31:0] CosC4     = 32'd296;

  localparam logic [30:0] MeanAngleReset     = 31'd0;
  localparam logic [31:0] ConcentrationReset = 32'd16777216;
  localparam logic [31:0] EnvelopeBoundReset = 32'd944066587;

  typedef enum logic [1:0] {
    RegMeanAngle     = 2'd0,
    RegConcentration = 2'd1,
    RegEnvelopeBound = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OutQuickReject = 2'd0,
    OutQuickAccept = 2'd1,
    OutSlowReject  = 2'd2,
    OutSlowAccept  = 2'd3
  } outcome_t;

  // divider step and log squaring step travel together
  typedef struct packed {
    logic        vld;
    logic [31:0] a;
    logic        neg;
    logic        ovf;
    logic [33:0] den;
    logic [33:0] rem;
    logic [29:0] low;
    logic [29:0] quo;
    logic [30:0] mant;
    logic [29:0] frac;
    logic [4:0]  lz;
  } loop_t;

  // cosine series and final compare
  typedef struct packed {
    logic        vld;
    logic        neg;
    logic        rej;
    logic        quick;
    logic        reduced;
    logic [29:0] mag;
    logic [31:0] u;
    logic [31:0] acc;
    logic [63:0] prod;
    logic [34:0] negln;
  } tail_t;

  // horner coefficients 1/(2n)! in q.30, innermost first after c4
  function automatic logic [31:0] horner_coef(input logic [1:0] step);
    logic [31:0] c;
    case (step)
      2'd0:    c = 32'd26631;
      2'd1:    c = 32'd1491308;
      2'd2:    c = 32'd44739243;
      default: c = 32'd536870912;
    endcase
    return c;
  endfunction

endpackage

/* rtl/von_mises_variate_trial.sv */
// von_mises_variate_trial: one ratio-of-uniforms von mises trial per item, fully pipelined
// throughput: one item per cycle unless the output stalls; 30 divider/squaring stages plus the cosine series set depth
// a stall on the output freezes the whole pipeline; uses rtl/vmvt_pkg.sv
// reset (rst, synchronous): clears all valid bits and loads the register defaults
`timescale 1ns / 1ps

module von_mises_variate_trial (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,    // uniform_a [31:0], uniform_b [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // accepted [0], outcome [2:1], sample [34:3], zero [39:35]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned TailLast = 11;

  // configuration registers
  logic [30:0] mean_angle;
  logic [31:0] concentration;
  logic [31:0] envelope_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_angle     <= vmvt_pkg::MeanAngleReset;
      concentration  <= vmvt_pkg::ConcentrationReset;
      envelope_bound <= vmvt_pkg::EnvelopeBoundReset;
    end else if (cfg_we) begin
      unique case (vmvt_pkg::cfg_reg_t'(cfg_addr))
        vmvt_pkg::RegMeanAngle:     mean_angle     <= cfg_wdata[30:0];
        vmvt_pkg::RegConcentration: concentration  <= cfg_wdata;
        vmvt_pkg::RegEnvelopeBound: envelope_bound <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: the output register frees up or is being taken
  logic en;
  logic out_vld;
  assign en       = !out_vld || m_tready;
  assign s_tready = en;

  // stage 1: |2*r2-1| in q1.32, numerator product, leading zero count of r1
  logic [31:0] in_a, in_b;
  logic        in_neg;
  logic [32:0] in_dmag;
  logic [4:0]  in_lz;
  assign in_a   = s_tdata[31:0];
  assign in_b   = s_tdata[63:32];
  assign in_neg = ~in_b[31];
  assign in_dmag = in_neg ? (33'h1_0000_0000 - {in_b, 1'b0})
                          : ({in_b, 1'b0} - 33'h1_0000_0000);

  always_comb begin
    in_lz = '0;
    for (int i = 0; i < 32; i++) begin
      if (in_a[i]) in_lz = 5'(31 - i);
    end
  end

  logic        s1_vld;
  logic [31:0] s1_a;
  logic        s1_neg;
  logic [64:0] s1_prod;
  logic [4:0]  s1_lz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= s_tvalid;
      s1_a    <= in_a;
      s1_neg  <= in_neg;
      s1_prod <= 65'(envelope_bound) * 65'(in_dmag);
      s1_lz   <= in_lz;
    end
  end

  // stage 2: overflow check (quotient would reach 2^30), divider seed, mantissa of r1
  vmvt_pkg::loop_t lp   [0:vmvt_pkg::LoopSteps];
  vmvt_pkg::loop_t lp_d [0:vmvt_pkg::LoopSteps];

  logic [31:0] s1_norm;
  logic [33:0] s1_den;
  assign s1_norm = s1_a << s1_lz;
  assign s1_den  = {s1_a, 2'b00};

  always_comb begin
    lp_d[0].vld  = s1_vld;
    lp_d[0].a    = s1_a;
    lp_d[0].neg  = s1_neg;
    // a zero r1 gives a zero divisor and always lands here as overflow
    lp_d[0].ovf  = s1_prod[64:30] >= {1'b0, s1_den};
    lp_d[0].den  = s1_den;
    lp_d[0].rem  = s1_prod[63:30];
    lp_d[0].low  = s1_prod[29:0];
    lp_d[0].quo  = '0;
    lp_d[0].mant = s1_norm[31:1];
    lp_d[0].frac = '0;
    lp_d[0].lz   = s1_lz;
  end

  // one restoring divide step and one mantissa squaring per stage
  function automatic vmvt_pkg::loop_t loop_step(input vmvt_pkg::loop_t t);
    vmvt_pkg::loop_t r;
    logic [34:0] rem2;
    logic [34:0] diff;
    logic        ge;
    logic [61:0] sq;
    logic [31:0] sh;
    r    = t;
    rem2 = {t.rem, t.low[29]};
    diff = rem2 - {1'b0, t.den};
    ge   = rem2 >= {1'b0, t.den};
    r.rem  = ge ? diff[33:0] : rem2[33:0];
    r.low  = {t.low[28:0], 1'b0};
    r.quo  = {t.quo[28:0], ge};
    sq     = 62'(t.mant) * 62'(t.mant);
    sh     = sq[61:30];
    r.mant = sh[31] ? sh[31:1] : sh[30:0];
    r.frac = {t.frac[28:0], sh[31]};
    return r;
  endfunction

  for (genvar k = 0; k < vmvt_pkg::LoopSteps; k++) begin : g_loop
    assign lp_d[k+1] = loop_step(lp[k]);
  end

  for (genvar k = 0; k <= vmvt_pkg::LoopSteps; k++) begin : g_loop_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        lp[k].vld <= 1'b0;
      end else if (en) begin
        lp[k] <= lp_d[k];
      end
    end
  end

  // post stage 1: theta magnitude, range fold, squares and log products
  vmvt_pkg::loop_t lp_end;
  logic [29:0]     pe_mag;
  logic            pe_reduced;
  assign lp_end     = lp[vmvt_pkg::LoopSteps];
  assign pe_mag     = lp_end.quo;
  assign pe_reduced = pe_mag > vmvt_pkg::HalfPiQ28;

  logic        p1_vld;
  logic        p1_neg;
  logic [31:0] p1_a;
  logic        p1_rej;
  logic        p1_reduced;
  logic [29:0] p1_mag;
  logic [29:0] p1_w28;
  logic [59:0] p1_t2p;
  logic [59:0] p1_flp;
  logic [34:0] p1_nlhi;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (en) begin
      p1_vld     <= lp_end.vld;
      p1_neg     <= lp_end.neg;
      p1_a       <= lp_end.a;
      p1_rej     <= lp_end.ovf || (pe_mag > vmvt_pkg::PiQ28);
      p1_reduced <= pe_reduced;
      p1_mag     <= pe_mag;
      p1_w28     <= pe_reduced ? (vmvt_pkg::PiQ28 - pe_mag) : pe_mag;
      p1_t2p     <= 60'(pe_mag) * 60'(pe_mag);
      p1_flp     <= 60'(lp_end.frac) * 60'(vmvt_pkg::Ln2Q30);
      // integer part of -log2(r1) is the leading zero count plus one
      p1_nlhi    <= 35'(6'(lp_end.lz) + 6'd1) * 35'(vmvt_pkg::Ln2Q30);
    end
  end

  // post stage 2: kappa*theta^2, -ln(r1) in q.30, w^2 for the cosine series
  logic [31:0] p1_w;
  assign p1_w = {p1_w28[29:0], 2'b00};

  logic        p2_vld;
  logic        p2_neg;
  logic        p2_rej;
  logic        p2_reduced;
  logic [29:0] p2_mag;
  logic [63:0] p2_lhs;
  logic [54:0] p2_rhs;
  logic [34:0] p2_negln;
  logic [61:0] p2_uprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (en) begin
      p2_vld     <= p1_vld;
      p2_neg     <= p1_neg;
      p2_rej     <= p1_rej;
      p2_reduced <= p1_reduced;
      p2_mag     <= p1_mag;
      p2_lhs     <= 64'(concentration) * 64'(p1_t2p[59:28]);
      p2_rhs     <= {33'h1_0000_0000 - {1'b0, p1_a}, 22'd0};
      p2_negln   <= p1_nlhi - 35'(p1_flp[59:30]);
      p2_uprod   <= 62'(p1_w) * 62'(p1_w);
    end
  end

  // tail: quick test, horner series for 1-cos(w), kappa product
  vmvt_pkg::tail_t tail   [0:TailLast];
  vmvt_pkg::tail_t tail_d [0:TailLast];

  logic [31:0] p2_u;
  assign p2_u = p2_uprod[61:30];

  always_comb begin
    tail_d[0].vld     = p2_vld;
    tail_d[0].neg     = p2_neg;
    tail_d[0].rej     = p2_rej;
    tail_d[0].quick   = p2_lhs < {9'd0, p2_rhs};
    tail_d[0].reduced = p2_reduced;
    tail_d[0].mag     = p2_mag;
    tail_d[0].u       = p2_u;
    // innermost step: c4 - u*2/2^30
    tail_d[0].acc     = vmvt_pkg::CosC4 - {29'd0, p2_u[31:29]};
    tail_d[0].prod    = '0;
    tail_d[0].negln   = p2_negln;
  end

  function automatic vmvt_pkg::tail_t mul_step(input vmvt_pkg::tail_t t);
    vmvt_pkg::tail_t r;
    r      = t;
    r.prod = 64'(t.u) * 64'(t.acc);
    return r;
  endfunction

  function automatic vmvt_pkg::tail_t sub_step(input vmvt_pkg::tail_t t,
                                               input logic [31:0] coef);
    vmvt_pkg::tail_t r;
    r     = t;
    r.acc = coef - t.prod[61:30];
    return r;
  endfunction

  for (genvar h = 0; h < 4; h++) begin : g_horner
    assign tail_d[2*h+1] = mul_step(tail[2*h]);
    assign tail_d[2*h+2] = sub_step(tail[2*h+1], vmvt_pkg::horner_coef(2'(h)));
  end

  // last series product gives 1-cos(w); fold back for w past pi/2
  assign tail_d[9] = mul_step(tail[8]);

  always_comb begin
    tail_d[10]     = tail[9];
    tail_d[10].acc = tail[9].reduced ? (vmvt_pkg::TwoQ30 - tail[9].prod[61:30])
                                     : tail[9].prod[61:30];
  end

  always_comb begin
    tail_d[11]      = tail[10];
    tail_d[11].prod = 64'(concentration) * 64'(tail[10].acc);
  end

  for (genvar k = 0; k <= TailLast; k++) begin : g_tail_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        tail[k].vld <= 1'b0;
      end else if (en) begin
        tail[k] <= tail_d[k];
      end
    end
  end

  // output stage: slow compare against -2*ln(r1) in q.54, theta + mu
  vmvt_pkg::tail_t    tl;
  vmvt_pkg::outcome_t fin_outcome;
  logic [63:0]        fin_srhs;
  logic [31:0]        fin_theta;
  logic [31:0]        fin_mu;
  assign tl        = tail[TailLast];
  assign fin_srhs  = {4'd0, tl.negln, 25'd0};
  assign fin_theta = tl.neg ? (32'd0 - {2'b00, tl.mag}) : {2'b00, tl.mag};
  assign fin_mu    = {mean_angle[30], mean_angle};

  always_comb begin
    if (tl.rej) begin
      fin_outcome = vmvt_pkg::OutQuickReject;
    end else if (tl.quick) begin
      fin_outcome = vmvt_pkg::OutQuickAccept;
    end else if (tl.prod > fin_srhs) begin
      fin_outcome = vmvt_pkg::OutSlowReject;
    end else begin
      fin_outcome = vmvt_pkg::OutSlowAccept;
    end
  end

  logic        out_accepted;
  logic [1:0]  out_outcome;
  logic [31:0] out_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld      <= tl.vld;
      out_accepted <= fin_outcome[0];
      out_outcome  <= fin_outcome;
      out_sample   <= fin_outcome[0] ? (fin_theta + fin_mu) : 32'd0;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {5'd0, out_sample, out_outcome, out_accepted};

`ifndef SYNTH
  // divider remainder stays below the divisor unless the quotient overflowed
  assert property (@(posedge clk) disable iff (rst)
    (lp[vmvt_pkg::LoopSteps].vld && !lp[vmvt_pkg::LoopSteps].ovf)
      |-> (lp[vmvt_pkg::LoopSteps].rem < lp[vmvt_pkg::LoopSteps].den))
    else $error("divider remainder not below divisor");

  // anything not rejected at range check has |theta| within pi
  assert property (@(posedge clk) disable iff (rst)
    (tail[0].vld && !tail[0].rej) |-> (tail[0].mag <= vmvt_pkg::PiQ28))
    else $error("unrejected theta beyond pi");

  // a stall freezes the output register
  assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(out_vld) && $stable(out_sample) && $stable(out_outcome)))
    else $error("output register moved during stall");

  // rejected items carry a zero sample and accepted flag matches outcome
  assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_outcome[0]) |-> (out_sample == 32'd0 && !out_accepted))
    else $error("rejected item with nonzero sample");
`endif

endmodule

/* sim/tb.sv */
// tb: self-checking testbench for von_mises_variate_trial, one uniform pair per item
// predicts every trial outcome in fixed point and checks each result in order
// depends on rtl/vmvt_pkg.sv and rtl/von_mises_variate_trial.sv
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 60;

  typedef struct packed {
    logic               accepted;
    vmvt_pkg::outcome_t outcome;
    logic [31:0]        sample;
  } trial_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;    // uniform_a [31:0], uniform_b [63:32]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;    // accepted [0], outcome [2:1], sample [34:3], zero [39:35]
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  // shadow copies of the block's registers
  logic [30:0] mu_reg;
  logic [31:0] kappa_reg;
  logic [31:0] bound_reg;

  trial_t pending_trials[$];
  int     error_count;
  int     cycle_count;
  int     stall_pct;       // receiver stall probability in percent
  int     hold_cycles;     // long receiver hold-off still to run
  int     sender_gap_max;  // longest gap between sender bursts

  von_mises_variate_trial u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // q.30 product, truncated toward zero
  function automatic longint mul_q30(longint x, longint y);
    logic        neg;
    logic [63:0] ux;
    logic [63:0] uy;
    logic [63:0] p;
    neg = (x < 0) != (y < 0);
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    p = (ux * uy) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // 1 - cos(v) in q.30 for v = |theta| in q4.28, v <= pi
  function automatic logic [63:0] one_minus_cos(logic [63:0] v);
    longint coef[6];
    logic   reduced;
    longint w;
    longint u;
    longint acc;
    coef[0] = 536870912; coef[1] = 44739243; coef[2] = 1491308;
    coef[3] = 26631;     coef[4] = 296;      coef[5] = 2;
    reduced = v > vmvt_pkg::HalfPiQ28;
    w = longint'(reduced ? 64'(vmvt_pkg::PiQ28) - v : v) <<< 2;
    u = mul_q30(w, w);
    acc = coef[5];
    for (int i = 4; i >= 0; i--) acc = coef[i] - mul_q30(u, acc);
    acc = mul_q30(u, acc);
    if (acc < 0) acc = 0;
    if (reduced) return 64'h8000_0000 - 64'(acc);
    return 64'(acc);
  endfunction

  // -ln(a / 2^32) in q.30 via leading bit and repeated squaring, a nonzero
  function automatic logic [63:0] neg_log(logic [31:0] a);
    int          p;
    logic [63:0] m;
    logic [63:0] frac;
    p = 31;
    while (!a[p]) p--;
    m = (p >= 30) ? (64'(a) >> (p - 30)) : (64'(a) << (30 - p));
    frac = 0;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return 64'(32 - p) * 64'(vmvt_pkg::Ln2Q30) - ((frac * 64'(vmvt_pkg::Ln2Q30)) >> 30);
  endfunction

  function automatic trial_t predict_trial(logic [31:0] a, logic [31:0] b);
    trial_t      r;
    logic        neg;
    logic [63:0] dmag;
    logic [63:0] mag;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [31:0] th;
    neg = b < 32'h8000_0000;
    dmag = neg ? 64'h1_0000_0000 - 64'(b) * 2 : 64'(b) * 2 - 64'h1_0000_0000;
    mag = (a != 0) ? (64'(bound_reg) * dmag) / (64'(a) * 4) : 64'd0;
    if (a == 0 || mag > vmvt_pkg::PiQ28) begin
      r.outcome = vmvt_pkg::OutQuickReject;
    end else begin
      lhs = 64'(kappa_reg) * ((mag * mag) >> 28);
      rhs = (64'h1_0000_0000 - 64'(a)) << 22;
      if (lhs < rhs) begin
        r.outcome = vmvt_pkg::OutQuickAccept;
      end else begin
        lhs = 64'(kappa_reg) * one_minus_cos(mag);
        rhs = neg_log(a) << 25;
        r.outcome = (lhs > rhs) ? vmvt_pkg::OutSlowReject : vmvt_pkg::OutSlowAccept;
      end
    end
    r.accepted = r.outcome[0];
    th = neg ? -mag[31:0] : mag[31:0];
    r.sample = r.accepted ? th + {mu_reg[30], mu_reg} : 32'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // result checker: compare against the oldest pending trial
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    trial_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_trials.size() == 0) begin
        $error("unexpected result item %h", m_tdata);
        error_count++;
      end else begin
        want = pending_trials.pop_front();
        if (m_tdata[0] !== want.accepted) begin
          $error("accepted: expected %0d actual %0d", want.accepted, m_tdata[0]);
          error_count++;
        end
        if (m_tdata[2:1] !== want.outcome) begin
          $error("outcome: expected %0d actual %0d", want.outcome, m_tdata[2:1]);
          error_count++;
        end
        if (m_tdata[34:3] !== want.sample) begin
          $error("sample: expected %h actual %h", want.sample, m_tdata[34:3]);
          error_count++;
        end
        if (m_tdata[39:35] !== 5'd0) begin
          $error("zero pad: expected 0 actual %h", m_tdata[39:35]);
          error_count++;
        end
      end
    end
  end

  // receiver: long hold-off when asked, else random stalls
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else if (stall_pct == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // drivers; each task starts and ends just after a rising edge
  // ---------------------------------------------------------------
  task automatic send_item(logic [31:0] a, logic [31:0] b);
    s_tvalid <= 1'b1;
    s_tdata <= {b, a};
    do @(posedge clk); while (!s_tready);
    pending_trials.push_back(predict_trial(a, b));
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // sender pause until every pending trial has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_trials.size() != 0);
  endtask

  // registers change only with the pipeline empty
  task automatic write_reg(vmvt_pkg::cfg_reg_t idx, logic [31:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vmvt_pkg::RegMeanAngle:     mu_reg = value[30:0];
      vmvt_pkg::RegConcentration: kappa_reg = value;
      default:                    bound_reg = value;
    endcase
  endtask

  task automatic set_regs(logic [31:0] mu, logic [31:0] kappa, logic [31:0] bound);
    write_reg(vmvt_pkg::RegMeanAngle, mu);
    write_reg(vmvt_pkg::RegConcentration, kappa);
    write_reg(vmvt_pkg::RegEnvelopeBound, bound);
  endtask

  // mostly a in the upper half so trials reach the slower tests
  task automatic random_items(int n);
    int          burst;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       a = $urandom_range(3);
        1, 2, 3: a = $urandom;
        default: a = 32'h8000_0000 | $urandom;
      endcase
      send_item(a, $urandom);
      if (burst <= 0) begin
        burst = $urandom_range(1, 20);
        idle_sender($urandom_range(0, sender_gap_max));
      end
      burst--;
    end
  endtask

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------
  task automatic test_directed();
    stall_pct = 0;
    // zero first uniform at both signs and at zero theta
    send_item(32'd0, 32'd0);
    send_item(32'd0, 32'hFFFF_FFFF);
    send_item(32'd0, 32'h8000_0000);
    // theta exactly zero, largest a, smallest a
    send_item(32'hFFFF_FFFF, 32'h8000_0000);
    send_item(32'd1, 32'h8000_0000);
    send_item(32'd1, 32'h8000_0001);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF);
    send_item(32'hC000_0000, 32'hA000_0000);
    send_item(32'hC000_0000, 32'h6000_0000);
    send_item(32'h4000_0000, 32'hB000_0000);
    send_item(32'hF000_0000, 32'hF000_0000);
    send_item(32'h9000_0000, 32'h0800_0000);
    send_item(32'h5555_5555, 32'hAAAA_AAAA);
    send_item(32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();
    // large kappa forces the cosine test, both branches of the reduction
    set_regs(32'h2000_0000, 32'h1000_0000, 32'h4000_0000);
    send_item(32'hE000_0000, 32'hA000_0000);
    send_item(32'hE000_0000, 32'h6000_0000);
    send_item(32'hFFFF_0000, 32'hC000_0000);
    send_item(32'hFFFF_0000, 32'hE800_0000);
    send_item(32'h2000_0000, 32'h8010_0000);
    // zero concentration: quick test always accepts
    set_regs(32'h4CBC_A8A9, 32'd0, 32'hC90F_DAA2);
    send_item(32'h8000_0000, 32'hC000_0000);
    send_item(32'h4000_0000, 32'h1000_0000);
    wait_drained();
  endtask

  task automatic test_random_settings();
    stall_pct = 25;
    sender_gap_max = 6;
    set_regs(32'd0, 32'h0100_0000, 32'd944066587);      // reset values
    random_items(120);
    set_regs(32'd843314857, 32'd1, 32'd3373259426);     // extremes
    random_items(90);
    set_regs(-32'sd843314857, 32'hFFFF_FFFF, 32'd0);
    random_items(60);
    stall_pct = 0;
    sender_gap_max = 0;                                 // no idling stretch
    set_regs(32'd123456789, 32'h0400_0000, 32'h2000_0000);
    random_items(120);
    stall_pct = 50;
    sender_gap_max = 10;
    set_regs(32'h7FFF_FFFF, 32'h0800_0000, 32'h1000_0000);
    random_items(60);
    for (int k = 0; k < 4; k++) begin
      set_regs($urandom, $urandom, $urandom);
      random_items(40);
    end
    set_regs($urandom_range(843314857), $urandom_range(32'h0100_0000, 32'h1000_0000),
             $urandom_range(32'h1000_0000, 32'h4000_0000));
    random_items(60);
  endtask

  // receiver holds off long enough that the pipeline fills and stalls its input
  task automatic test_backpressure();
    stall_pct = 10;
    wait_drained();
    hold_cycles = 300;
    sender_gap_max = 0;
    random_items(100);
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    m_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= vmvt_pkg::RegMeanAngle;
    cfg_wdata <= '0;
    mu_reg = vmvt_pkg::MeanAngleReset;
    kappa_reg = vmvt_pkg::ConcentrationReset;
    bound_reg = vmvt_pkg::EnvelopeBoundReset;
    error_count = 0;
    cycle_count = 0;
    stall_pct = 0;
    hold_cycles = 0;
    sender_gap_max = 4;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_settings();
    test_backpressure();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && pending_trials.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/vmvt_pkg.sv
rtl/von_mises_variate_trial.sv
sim/tb.sv
